// ===== rtl/core/btbp_pkg.sv =====
// Shared constants, state codes and update functions of the branch predictor.
package btbp_pkg;

    localparam int MAX_ENTRIES_DEF  = 2048;
    localparam int ADDR_W           = 32;
    localparam int COUNT_W          = 32;
    localparam int CFG_W            = 4;
    localparam int INDEX_BITS_MIN   = 4;
    localparam int INDEX_BITS_RESET = 11;

    typedef logic [1:0] t_ctr;

    localparam t_ctr ST_STRONG_TAKEN     = 2'b11;
    localparam t_ctr ST_WEAK_TAKEN       = 2'b10;
    localparam t_ctr ST_WEAK_NOT_TAKEN   = 2'b01;
    localparam t_ctr ST_STRONG_NOT_TAKEN = 2'b00;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Hysteresis update: a hit goes strong on its side, a miss steps toward the weak states.
    function automatic t_ctr next_state(input t_ctr st, input logic hit);
        t_ctr nxt;
        nxt = st;
        if (hit) begin
            nxt = st[1] ? ST_STRONG_TAKEN : ST_STRONG_NOT_TAKEN;
        end else begin
            case (st)
                ST_STRONG_TAKEN:     nxt = ST_WEAK_TAKEN;
                ST_WEAK_TAKEN:       nxt = ST_WEAK_NOT_TAKEN;
                ST_WEAK_NOT_TAKEN:   nxt = ST_WEAK_TAKEN;
                ST_STRONG_NOT_TAKEN: nxt = ST_WEAK_NOT_TAKEN;
                default:             nxt = ST_WEAK_NOT_TAKEN;
            endcase
        end
        return nxt;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
    endfunction

endpackage

// ===== rtl/core/btbp_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module btbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/bimodal_two_bit_branch_predictor.sv =====
// Bimodal two-bit branch predictor with hysteresis: top level.
// Path: RAM read into stage 1, then the output register, which drives o_valid.
// Throughput: one branch per cycle while o_stall is low; the counter table is one RAM read and one
// write per cycle, with the last write forwarded to a read of the same entry that overlaps it.
// Reset: synchronous; afterwards a clearing pass writes strongly taken into all MAX_ENTRIES
// entries, one per cycle, and input is stalled until the pass ends.
module bimodal_two_bit_branch_predictor #(
    parameter int MAX_ENTRIES = btbp_pkg::MAX_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // branch input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [btbp_pkg::ADDR_W-1:0]   i_branch_address,
    input  logic                          i_taken,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_predicted_taken,
    output logic                          o_was_correct,
    output logic [btbp_pkg::COUNT_W-1:0]  o_correct_total,
    output logic [btbp_pkg::COUNT_W-1:0]  o_branch_total,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [btbp_pkg::CFG_W-1:0]    i_cfg_data
);
    import btbp_pkg::*;

    localparam int AW       = $clog2(MAX_ENTRIES);
    localparam int MAX_BITS = $clog2(MAX_ENTRIES + 1) - 1;
    localparam int RST_BITS = (INDEX_BITS_RESET > MAX_BITS) ? MAX_BITS : INDEX_BITS_RESET;

    // configuration, stored already clamped to the usable range
    logic [CFG_W-1:0] r_eff_bits;
    logic [CFG_W-1:0] n_eff_bits;

    // clearing pass
    logic          r_clr_active;
    logic [AW-1:0] r_clr_addr;

    // stage 1: RAM data available
    logic          r_s1_valid;
    logic [AW-1:0] r_s1_idx;
    logic          r_s1_taken;

    // last table write, forwarded to an overlapping read
    logic          r_fwd_valid;
    logic [AW-1:0] r_fwd_idx;
    t_ctr          r_fwd_val;

    // counters
    logic [COUNT_W-1:0] r_correct;
    logic [COUNT_W-1:0] r_branch;

    // output register
    logic               r_out_valid;
    logic               r_out_pred;
    logic               r_out_ok;
    logic [COUNT_W-1:0] r_out_correct;
    logic [COUNT_W-1:0] r_out_branch;

    logic          in_accept;
    logic          s1_adv;
    logic [AW-1:0] idx_mask;
    logic [AW-1:0] rd_idx;
    t_ctr          ram_rd_data;
    t_ctr          s1_state;
    logic          s1_pred;
    logic          s1_ok;
    t_ctr          s1_next;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_ctr          wr_data;
    logic [COUNT_W-1:0] n_correct;
    logic [COUNT_W-1:0] n_branch;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_eff_bits = i_cfg_data;
        if ({1'b0, i_cfg_data} < 5'(INDEX_BITS_MIN)) begin
            n_eff_bits = CFG_W'(INDEX_BITS_MIN);
        end else if ({1'b0, i_cfg_data} > 5'(MAX_BITS)) begin
            n_eff_bits = CFG_W'(MAX_BITS);
        end
    end

    always_comb begin
        for (int i = 0; i < AW; i++) begin
            idx_mask[i] = (5'(i) < {1'b0, r_eff_bits});
        end
    end

    assign rd_idx = i_branch_address[AW-1:0] & idx_mask;

    // hold stage 1 while the output register is full and not taken
    assign s1_adv    = r_s1_valid & (~r_out_valid | ~i_stall);
    assign o_stall   = r_clr_active | (r_s1_valid & ~s1_adv);
    assign in_accept = i_valid & ~o_stall;

    assign s1_state = (r_fwd_valid && (r_fwd_idx == r_s1_idx)) ? r_fwd_val : ram_rd_data;
    assign s1_pred  = s1_state[1];
    assign s1_ok    = (s1_pred == r_s1_taken);
    assign s1_next  = next_state(s1_state, s1_ok);

    assign n_branch  = sat_inc(r_branch);
    assign n_correct = s1_ok ? sat_inc(r_correct) : r_correct;

    always_comb begin
        if (r_clr_active) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = ST_STRONG_TAKEN;
        end else begin
            wr_en   = s1_adv;
            wr_addr = r_s1_idx;
            wr_data = s1_next;
        end
    end

    btbp_ram #(
        .WIDTH ($bits(t_ctr)),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (in_accept),
        .i_rd_addr (rd_idx),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_bits   <= CFG_W'(RST_BITS);
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_s1_valid   <= 1'b0;
            r_fwd_valid  <= 1'b0;
            r_correct    <= '0;
            r_branch     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_eff_bits <= n_eff_bits;
            end
            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(MAX_ENTRIES - 1)) begin
                    r_clr_active <= 1'b0;
                end
            end
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_fwd_valid <= 1'b1;
                r_correct   <= n_correct;
                r_branch    <= n_branch;
                r_out_valid <= 1'b1;
            end else if (~i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_idx   <= rd_idx;
            r_s1_taken <= i_taken;
        end
        if (s1_adv) begin
            r_fwd_idx     <= r_s1_idx;
            r_fwd_val     <= s1_next;
            r_out_pred    <= s1_pred;
            r_out_ok      <= s1_ok;
            r_out_correct <= n_correct;
            r_out_branch  <= n_branch;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_predicted_taken = r_out_pred;
    assign o_was_correct     = r_out_ok;
    assign o_correct_total   = r_out_correct;
    assign o_branch_total    = r_out_branch;

endmodule
